[hdl/single_wire_sensor_edge_decoder_defines.svh]
// Assertion macros used by the edge decoder checker.
`ifndef SINGLE_WIRE_SENSOR_EDGE_DECODER_DEFINES_SVH
`define SINGLE_WIRE_SENSOR_EDGE_DECODER_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define SWSED_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swsed same-cycle check failed");

// Next-cycle implication, masked while reset is high.
`define SWSED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swsed next-cycle check failed");

// Next-cycle implication that is checked during reset too.
`define SWSED_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("swsed reset check failed");

`endif

[hdl/swsed_pkg.sv]
// Types and constants of the single-wire sensor edge decoder.
package swsed_pkg;

  localparam int FRAME_BITS = 40;
  localparam int BITS_W     = $clog2(FRAME_BITS + 1);

  localparam logic [15:0] SENSOR_PIN_RST    = 16'd16;
  localparam logic [15:0] ONE_THRESHOLD_RST = 16'd100;

  // Configuration register indexes
  localparam logic REG_SENSOR_PIN    = 1'b0;
  localparam logic REG_ONE_THRESHOLD = 1'b1;

  // Opcodes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Decode phases
  localparam logic [2:0] PH_WAKING     = 3'd0;
  localparam logic [2:0] PH_RESP_START = 3'd1;
  localparam logic [2:0] PH_RESP_STOP  = 3'd2;
  localparam logic [2:0] PH_RECEIVING  = 3'd3;
  localparam logic [2:0] PH_RECEIVED   = 3'd4;

  // Frame byte that carries the temperature
  localparam logic [2:0] TEMP_BYTE = 3'd2;

  typedef struct packed {
    logic        opcode;
    logic [15:0] edge_pin;
    logic [15:0] interval_ticks;
  } in_beat_t;

  typedef struct packed {
    logic       data_ready;
    logic [7:0] temperature;
    logic [2:0] phase;
  } out_beat_t;

endpackage

[hdl/single_wire_sensor_edge_decoder.sv]
// Single-wire sensor edge decoder: phase machine, bit packer and result buffer.
// Result: a result beat is registered and appears in the cycle after its input beat is
//   accepted while the output is free; behind a stalled result it waits in the skid entry.
// Throughput: one beat per cycle while the skid is empty; all decode work sits between
//   the accept edge and the result register; a one-entry skid sits behind the output register.
// Reset (rst, synchronous, active high): phase waking, counters, frame byte and
//   temperature cleared, sensor_pin 16, one_threshold 100, output and skid empty.
module single_wire_sensor_edge_decoder
  import swsed_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  // configuration write port
  input  logic      cfg_we,
  input  logic      cfg_addr,
  input  logic [15:0] cfg_wdata,
  // input channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  // Configuration registers
  logic [15:0] sensor_pin;
  logic [15:0] one_threshold;

  // Decoder state
  logic [2:0]        phase, phase_next;
  logic [BITS_W-1:0] bits_received, bits_received_next;
  logic [7:0]        partial_byte, partial_byte_next;
  logic [2:0]        bit_position, bit_position_next;
  logic [2:0]        byte_slot, byte_slot_next;
  logic [7:0]        temp_byte, temp_byte_next;       // frame byte 2; other bytes are never read
  logic [7:0]        temperature_latch, temperature_latch_next;

  // Result buffer
  out_beat_t   result;
  out_beat_t   skid_data;
  logic        skid_valid;

  logic              in_acc;
  logic              out_take;
  logic              pin_match;
  logic              bit_one;
  logic [7:0]        packed_byte;
  logic [BITS_W-1:0] bits_inc;

  // Hold input only while the skid entry is occupied; the output register
  // plus skid lets a new beat in while a finished result waits.
  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  assign pin_match = (in_data.edge_pin == sensor_pin);
  assign bit_one   = (in_data.interval_ticks > one_threshold);
  assign bits_inc  = bits_received + BITS_W'(1);

  // Decode one beat: advance the phase on matched edges, pack a bit while
  // receiving, and on a poll of a complete frame latch the temperature byte.
  always_comb begin
    phase_next             = phase;
    bits_received_next     = bits_received;
    partial_byte_next      = partial_byte;
    bit_position_next      = bit_position;
    byte_slot_next         = byte_slot;
    temp_byte_next         = temp_byte;
    temperature_latch_next = temperature_latch;
    packed_byte            = partial_byte;
    result.data_ready      = 1'b0;

    // Bit lands MSB first at position 7 - bit_position.
    packed_byte[3'd7 - bit_position] = bit_one;

    if (in_data.opcode == OP_EDGE) begin
      if (pin_match) begin
        case (phase)
          PH_WAKING:     phase_next = PH_RESP_START;
          PH_RESP_START: phase_next = PH_RESP_STOP;
          PH_RESP_STOP:  phase_next = PH_RECEIVING;
          PH_RECEIVING: begin
            bits_received_next = bits_inc;
            if (bit_position == 3'd7) begin
              // Byte complete: store it if it is the temperature slot.
              if (byte_slot == TEMP_BYTE) begin
                temp_byte_next = packed_byte;
              end
              partial_byte_next = 8'd0;
              byte_slot_next    = byte_slot + 3'd1;
              bit_position_next = 3'd0;
            end else begin
              partial_byte_next = packed_byte;
              bit_position_next = bit_position + 3'd1;
            end
            // Frame end: drop any trailing partial bits and hold until polled.
            if (bits_inc >= BITS_W'(FRAME_BITS)) begin
              bits_received_next = '0;
              byte_slot_next     = 3'd0;
              bit_position_next  = 3'd0;
              partial_byte_next  = 8'd0;
              phase_next         = PH_RECEIVED;
            end
          end
          PH_RECEIVED:   phase_next = PH_RECEIVED;
          default:       phase_next = PH_WAKING;
        endcase
      end
    end else if (phase == PH_RECEIVED) begin
      temperature_latch_next = temp_byte;
      phase_next             = PH_WAKING;
      result.data_ready      = 1'b1;
    end

    result.temperature = temperature_latch_next;
    result.phase       = phase_next;
  end

  // Configuration writes; the user must write the port only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_pin    <= SENSOR_PIN_RST;
      one_threshold <= ONE_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SENSOR_PIN:    sensor_pin    <= cfg_wdata;
        REG_ONE_THRESHOLD: one_threshold <= cfg_wdata;
        default:           sensor_pin    <= sensor_pin;
      endcase
    end
  end

  // Advance decoder state on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_WAKING;
      bits_received     <= '0;
      partial_byte      <= 8'd0;
      bit_position      <= 3'd0;
      byte_slot         <= 3'd0;
      temp_byte         <= 8'd0;
      temperature_latch <= 8'd0;
    end else if (in_acc) begin
      phase             <= phase_next;
      bits_received     <= bits_received_next;
      partial_byte      <= partial_byte_next;
      bit_position      <= bit_position_next;
      byte_slot         <= byte_slot_next;
      temp_byte         <= temp_byte_next;
      temperature_latch <= temperature_latch_next;
    end
  end

  // Output register and skid entry. A result goes straight to the output when
  // it is empty or being taken; otherwise park it in the skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid || out_take) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hdl/swsed_checker.sv]
// Port-level checker for the edge decoder and its bind.
`include "single_wire_sensor_edge_decoder_defines.svh"

module swsed_checker
  import swsed_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // A poll that found a frame always drops the block back to waking.
  `SWSED_ASSERT_IMP(a_ready_wakes, clk, rst, out_valid && out_data.data_ready, out_data.phase == PH_WAKING)

  // Input is held back only while a result is already waiting.
  `SWSED_ASSERT_IMP(a_stall_needs_out, clk, rst, in_stall, out_valid)

  // A beat accepted into an empty output shows up on the next cycle.
  `SWSED_ASSERT_NEXT(a_empty_fill, clk, rst, in_valid && !in_stall && !out_valid, out_valid)

  // Reset empties the result channel.
  `SWSED_ASSERT_RST(a_rst_empty, clk, rst, !out_valid)

  // A stalled result beat holds.
  `SWSED_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind single_wire_sensor_edge_decoder swsed_checker u_swsed_checker (.*);
